// ===== design/kmh_pkg.sv =====
package kmh_pkg;

    // default sizes
    localparam int MAX_LISTS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int SRC_W    = 4;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXHAUST = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_OUT
    } state_t;

endpackage

// ===== design/k_way_merge_min_heap.sv =====
// K-way merge engine around a binary min-heap of (value, source) entries.
// Input channel (in_valid/in_ready) takes one command word: load a list head,
// pop the minimum and refill from the same list, or pop and drop the list.
// Output channel (out_valid/out_ready) returns exactly one result word per
// command: status, popped item if any, the source of the new minimum and the
// live entry count.
// One command is worked at a time; in_ready is high only while idle.
// Each level takes one registered read of the heap RAM, then one pass through
// the compare unit with a write back.
// A load moves the new entry up from the end; a pop moves the filling entry
// down from the root; error and unused commands go straight to the result.
// The next command can be taken in the cycle after its result is taken, so
// commands never overlap.
// Reset empties the heap at once; the entry RAM needs no clearing.
// A result waits in its registers until out_ready; the engine holds meanwhile.
module k_way_merge_min_heap #(
    parameter int MAX_LISTS  = kmh_pkg::MAX_LISTS_DEF,
    parameter int VALUE_BITS = kmh_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [kmh_pkg::CMD_W-1:0]          cmd,
    input  logic signed [VALUE_BITS-1:0]       value,
    input  logic [kmh_pkg::SRC_W-1:0]          source,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [kmh_pkg::STATUS_W-1:0]       status,
    output logic                               has_item,
    output logic signed [VALUE_BITS-1:0]       out_value,
    output logic [kmh_pkg::SRC_W-1:0]          out_source,
    output logic [kmh_pkg::SRC_W-1:0]          next_source,
    output logic [$clog2(MAX_LISTS+1)-1:0]     live_count
);

    import kmh_pkg::*;

    localparam int IDX_W = $clog2(MAX_LISTS);
    localparam int CNT_W = $clog2(MAX_LISTS + 1);
    localparam int EXT_W = IDX_W + 2;
    localparam int ENT_W = VALUE_BITS + SRC_W;

    // heap order: signed value, then lower source
    function automatic logic ent_less(
        input logic [VALUE_BITS-1:0] va,
        input logic [SRC_W-1:0]      sa,
        input logic [VALUE_BITS-1:0] vb,
        input logic [SRC_W-1:0]      sb
    );
        logic res;
        if (va != vb)
        begin
            res = $signed(va) < $signed(vb);
        end
        else
        begin
            res = sa < sb;
        end
        return res;
    endfunction

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [VALUE_BITS-1:0] x_val_reg, x_val_next;
    logic [SRC_W-1:0]      x_src_reg, x_src_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [SRC_W-1:0]      top_src_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  has_reg, has_next;
    logic [VALUE_BITS-1:0] oval_reg, oval_next;
    logic [SRC_W-1:0]      osrc_reg, osrc_next;

    // ram side
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [ENT_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    kmh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LISTS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    logic [VALUE_BITS-1:0] a_val, b_val, c_val;
    logic [SRC_W-1:0]      a_src, b_src, c_src;
    assign a_val = ram_rdata_a[ENT_W-1:SRC_W];
    assign a_src = ram_rdata_a[SRC_W-1:0];
    assign b_val = ram_rdata_b[ENT_W-1:SRC_W];
    assign b_src = ram_rdata_b[SRC_W-1:0];

    // index arithmetic
    logic [EXT_W-1:0] left_ext, right_ext, count_ext;
    logic [IDX_W-1:0] parent_idx, child_idx, last_idx;
    logic             in_acc, out_acc, heap_full, heap_empty;
    logic             left_in, right_in, pick_right, up_less, dn_less;

    assign left_ext   = {1'b0, idx_reg, 1'b1};
    assign right_ext  = left_ext + EXT_W'(1);
    assign count_ext  = {{(EXT_W-CNT_W){1'b0}}, count_reg};
    assign parent_idx = IDX_W'((idx_reg - IDX_W'(1)) >> 1);
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign left_in    = left_ext < count_ext;
    assign right_in   = right_ext < count_ext;
    assign heap_full  = count_reg == CNT_W'(MAX_LISTS);
    assign heap_empty = count_reg == '0;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // compare unit
    assign pick_right = right_in && ent_less(b_val, b_src, a_val, a_src);
    assign c_val      = pick_right ? b_val : a_val;
    assign c_src      = pick_right ? b_src : a_src;
    assign child_idx  = pick_right ? right_ext[IDX_W-1:0] : left_ext[IDX_W-1:0];
    assign up_less    = ent_less(x_val_reg, x_src_reg, a_val, a_src);
    assign dn_less    = ent_less(c_val, c_src, x_val_reg, x_src_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        state_next = heap_full ? ST_OUT : ST_UP_RD;
                    end
                    else if (cmd == CMD_REFILL || cmd == CMD_EXHAUST)
                    begin
                        state_next = heap_empty ? ST_OUT : ST_POP;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_DN_RD;
            end
            ST_UP_RD:
            begin
                state_next = (idx_reg == '0) ? ST_OUT : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                state_next = up_less ? ST_UP_RD : ST_OUT;
            end
            ST_DN_RD:
            begin
                state_next = left_in ? ST_DN_CMP : ST_OUT;
            end
            ST_DN_CMP:
            begin
                state_next = dn_less ? ST_DN_RD : ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        x_val_next  = x_val_reg;
        x_src_next  = x_src_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        has_next    = has_reg;
        oval_next   = oval_reg;
        osrc_next   = osrc_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = {x_val_reg, x_src_reg};
        ram_raddr_a = '0;
        ram_raddr_b = last_idx;
        case (state_reg)
            ST_IDLE:
            begin
                // root and last entry are read for a pop
                ram_raddr_a = '0;
                ram_raddr_b = last_idx;
                if (in_acc)
                begin
                    cmd_next    = cmd;
                    x_val_next  = value;
                    x_src_next  = source;
                    status_next = STAT_OK;
                    has_next    = 1'b0;
                    oval_next   = '0;
                    osrc_next   = '0;
                    if (cmd == CMD_LOAD)
                    begin
                        if (heap_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            idx_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd == CMD_REFILL || cmd == CMD_EXHAUST)
                    begin
                        if (heap_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                end
            end
            ST_POP:
            begin
                // emit the root, pick the entry that fills the hole
                has_next  = 1'b1;
                oval_next = a_val;
                osrc_next = a_src;
                idx_next  = '0;
                if (cmd_reg == CMD_REFILL)
                begin
                    x_src_next = a_src;
                end
                else
                begin
                    x_val_next = b_val;
                    x_src_next = b_src;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_UP_RD:
            begin
                ram_raddr_a = parent_idx;
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (up_less)
                begin
                    // parent moves down into the hole
                    ram_wdata = ram_rdata_a;
                    idx_next  = parent_idx;
                end
            end
            ST_DN_RD:
            begin
                ram_raddr_a = left_ext[IDX_W-1:0];
                ram_raddr_b = right_ext[IDX_W-1:0];
                if (!left_in)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (dn_less)
                begin
                    // smaller child moves up into the hole
                    ram_wdata = {c_val, c_src};
                    idx_next  = child_idx;
                end
            end
            ST_OUT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        x_val_reg  <= x_val_next;
        x_src_reg  <= x_src_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        has_reg    <= has_next;
        oval_reg   <= oval_next;
        osrc_reg   <= osrc_next;
        if (ram_we && ram_waddr == '0)
        begin
            top_src_reg <= ram_wdata[SRC_W-1:0];
        end
    end

    // result word
    assign in_ready    = state_reg == ST_IDLE;
    assign out_valid   = state_reg == ST_OUT;
    assign status      = status_reg;
    assign has_item    = has_reg;
    assign out_value   = oval_reg;
    assign out_source  = osrc_reg;
    assign next_source = heap_empty ? '0 : top_src_reg;
    assign live_count  = count_reg;

endmodule

// ===== design/kmh_ram.sv =====
module kmh_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/kmh_checker.sv =====
module kmh_checker #(
    parameter int MAX_LISTS  = kmh_pkg::MAX_LISTS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [kmh_pkg::STATUS_W-1:0]       status,
    input logic                               has_item,
    input logic [kmh_pkg::SRC_W-1:0]          next_source,
    input logic [$clog2(MAX_LISTS+1)-1:0]     live_count
);

    import kmh_pkg::*;

    localparam int CNT_W = $clog2(MAX_LISTS + 1);

    // engine is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready while a command is in flight");

    // one result per command: taken result does not repeat
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result shown twice");

    // a popped item only comes with ok status
    a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_item |-> status == STAT_OK)
        else $error("popped item with error status");

    // empty heap reports source zero
    a_empty_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && live_count == '0 |-> next_source == '0)
        else $error("next source on empty heap");

    // full error only when the heap is full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> live_count == CNT_W'(MAX_LISTS))
        else $error("full status with room left");

endmodule

bind k_way_merge_min_heap kmh_checker #(
    .MAX_LISTS  (MAX_LISTS)
) u_kmh_checker (.*);

// ===== tb/tb_k_way_merge_min_heap.sv =====
`timescale 1ns / 1ps

module tb_k_way_merge_min_heap;

    import kmh_pkg::*;

    localparam int NLISTS      = MAX_LISTS_DEF;
    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int LIVE_W      = $clog2(NLISTS + 1);
    localparam int HOLD_CYCLES = 250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    // the cmd encoding left unused by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [VBITS-1:0] VAL_MIN = {1'b1, {(VBITS-1){1'b0}}};
    localparam logic signed [VBITS-1:0] VAL_MAX = {1'b0, {(VBITS-1){1'b1}}};

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    has_item;
        logic signed [VBITS-1:0] value;
        logic [SRC_W-1:0]        src;
        logic [SRC_W-1:0]        next_src;
        logic [LIVE_W-1:0]       live;
    } merge_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [CMD_W-1:0]        cmd = '0;
    logic signed [VBITS-1:0] value = '0;
    logic [SRC_W-1:0]        source = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic                    has_item;
    logic signed [VBITS-1:0] out_value;
    logic [SRC_W-1:0]        out_source;
    logic [SRC_W-1:0]        next_source;
    logic [LIVE_W-1:0]       live_count;

    // golden heap of (value, source) entries
    logic signed [VBITS-1:0] pq_value [NLISTS];
    logic [SRC_W-1:0]        pq_source [NLISTS];
    int                      pq_count = 0;

    merge_result_t pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            quiet = 1'b0;
    bit            hold_go = 1'b0;
    bit            hold_active = 1'b0;

    k_way_merge_min_heap dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value       (value),
        .source      (source),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .has_item    (has_item),
        .out_value   (out_value),
        .out_source  (out_source),
        .next_source (next_source),
        .live_count  (live_count)
    );

    always #5 clk = ~clk;

    // heap order: signed value, then lower source
    function automatic bit entry_before(int a, int b);
        if (pq_value[a] != pq_value[b])
            return pq_value[a] < pq_value[b];
        return pq_source[a] < pq_source[b];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic signed [VBITS-1:0] v;
        logic [SRC_W-1:0]        s;
        v = pq_value[a];
        s = pq_source[a];
        pq_value[a] = pq_value[b];
        pq_source[a] = pq_source[b];
        pq_value[b] = v;
        pq_source[b] = s;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!entry_before(i, p))
                break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down();
        int i;
        int l;
        int c;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            if (l >= pq_count)
                break;
            c = l;
            if (l + 1 < pq_count && entry_before(l + 1, l))
                c = l + 1;
            if (!entry_before(c, i))
                break;
            swap_entries(c, i);
            i = c;
        end
    endfunction

    // apply one command word to the golden heap and build its result
    function automatic merge_result_t predict_merge_result(logic [CMD_W-1:0] c,
                                                           logic signed [VBITS-1:0] v,
                                                           logic [SRC_W-1:0] s);
        merge_result_t r;
        r = '0;
        r.status = STAT_OK;
        if (c == CMD_LOAD)
        begin
            if (pq_count >= NLISTS)
                r.status = STAT_FULL;
            else
            begin
                pq_value[pq_count] = v;
                pq_source[pq_count] = s;
                pq_count++;
                bubble_up(pq_count - 1);
            end
        end
        else if (c == CMD_REFILL || c == CMD_EXHAUST)
        begin
            if (pq_count == 0)
                r.status = STAT_EMPTY;
            else
            begin
                r.has_item = 1'b1;
                r.value = pq_value[0];
                r.src = pq_source[0];
                if (c == CMD_REFILL)
                    pq_value[0] = v;
                else
                begin
                    pq_count--;
                    pq_value[0] = pq_value[pq_count];
                    pq_source[0] = pq_source[pq_count];
                end
                bubble_down();
            end
        end
        r.next_src = (pq_count > 0) ? pq_source[0] : '0;
        r.live = pq_count[LIVE_W-1:0];
        return r;
    endfunction

    // value mix: extremes, a narrow band for ties, full random
    function automatic logic signed [VBITS-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (sel <= 3)
            return $signed($urandom_range(0, 15)) - 8;
        return $urandom;
    endfunction

    // offer one word, starting and ending at a falling edge
    task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [VBITS-1:0] v,
                             input logic [SRC_W-1:0] s);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        source <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_merge_result(c, v, s));
        @(negedge clk);
    endtask

    // load sessions then pops until empty, with some noise words mixed in
    task automatic run_merges(input int n);
        int sent;
        int k;
        sent = 0;
        while (sent < n)
        begin
            k = $urandom_range(1, NLISTS);
            while (pq_count < k && sent < n)
            begin
                send_word(CMD_LOAD, pick_value(), SRC_W'($urandom_range(0, 15)));
                sent++;
            end
            while (pq_count > 0 && sent < n)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_word(CMD_W'($urandom_range(0, 3)), pick_value(),
                              SRC_W'($urandom_range(0, 15)));
                else if ($urandom_range(0, 2) == 0)
                    send_word(CMD_EXHAUST, pick_value(), SRC_W'($urandom_range(0, 15)));
                else
                    send_word(CMD_REFILL, pick_value(), SRC_W'($urandom_range(0, 15)));
                sent++;
            end
            // occasional pop past the end of a merge
            if (sent < n && $urandom_range(0, 2) == 0)
            begin
                send_word($urandom_range(0, 1) ? CMD_REFILL : CMD_EXHAUST, pick_value(),
                          SRC_W'($urandom_range(0, 15)));
                sent++;
            end
        end
    endtask

    task automatic test_empty_heap();
        send_word(CMD_EXHAUST, VAL_MAX, 4'hf);
        send_word(CMD_REFILL, VAL_MIN, 4'h0);
        send_word(CMD_UNUSED, '1, 4'ha);
    endtask

    // extremes, tied values and a repeated source, then one load too many
    task automatic test_fill_and_full();
        logic signed [VBITS-1:0] vals [NLISTS];
        logic [SRC_W-1:0]        srcs [NLISTS];
        vals = '{VAL_MAX, VAL_MIN, 0, -1, 5, 5, 5, 1, VAL_MIN, VAL_MAX, -2, 7, 7, 0, 3, 100};
        srcs = '{4'd15, 4'd0, 4'd3, 4'd9, 4'd6, 4'd1, 4'd1, 4'd12, 4'd15, 4'd2,
                 4'd5, 4'd8, 4'd7, 4'd0, 4'd11, 4'd4};
        for (int i = 0; i < NLISTS; i++)
            send_word(CMD_LOAD, vals[i], srcs[i]);
        send_word(CMD_LOAD, VAL_MIN, 4'd0);
    endtask

    // refill keeps the popped source, the source field is ignored
    task automatic test_refill_exhaust();
        send_word(CMD_REFILL, VAL_MAX, 4'd10);
        send_word(CMD_REFILL, VAL_MIN, 4'd13);
        send_word(CMD_UNUSED, VAL_MAX, 4'd0);
        send_word(CMD_EXHAUST, 0, 4'd6);
    endtask

    task automatic test_random_merge();
        run_merges(1250);
    endtask

    // receiver stops for a long stretch while words keep coming
    task automatic test_output_backpressure();
        hold_go = 1'b1;
        run_merges(40);
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        run_merges(250);
    endtask

    // long receiver hold-off
    always
    begin
        wait (hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_go = 1'b0;
    end

    // receiver ready with random stall bursts
    always @(negedge clk)
    begin
        static int stall_left = 0;
        logic rdy;
        rdy = 1'b1;
        if (quiet)
            stall_left = 0;
        else if (stall_left > 0)
        begin
            rdy = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            rdy = 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        out_ready <= rdy && !hold_active;
    end

    function automatic void check_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endfunction

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        merge_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.status, status);
                check_field("has_item", e.has_item, has_item);
                check_field("out_value", e.value, out_value);
                check_field("out_source", e.src, out_source);
                check_field("next_source", e.next_src, next_source);
                check_field("live_count", e.live, live_count);
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_heap();
        test_fill_and_full();
        test_refill_exhaust();
        test_random_merge();
        test_output_backpressure();
        test_streaming();
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/kmh_pkg.sv
design/kmh_ram.sv
design/k_way_merge_min_heap.sv
design/kmh_checker.sv
tb/tb_k_way_merge_min_heap.sv
